// ----- design/wdba_pkg.sv -----
// ----------------------------------------------------------------------------
// wdba_pkg
// Shared widths, constants and the arctangent table of the beamform accumulator.
// ----------------------------------------------------------------------------
package wdba_pkg;

  localparam int unsigned AccWidthDef   = 48;
  localparam int unsigned PhaseBitsDef  = 16;
  localparam int unsigned PosWidth      = 24;
  localparam int unsigned DirWidth      = 48;
  localparam int unsigned OutWidth      = 48;
  localparam int unsigned CordicSteps   = 16;
  localparam int unsigned StepWidth     = 4;
  localparam int unsigned NumSamples    = 4;
  localparam int unsigned SelWidth      = 2;

  localparam logic [31:0] CordicGain    = 32'h26DD3B6A;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_ACCUM = 1'b1
  } func_e;

  typedef struct packed {
    logic load_item;
    logic start_point;
    logic dir_step;
    logic phase_step;
    logic cordic_init;
    logic cordic_step;
    logic cordic_done;
    logic weight_step;
    logic mac_step;
    logic [SelWidth-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic is_accum;
    logic is_last;
  } stat_t;

  function automatic logic signed [33:0] atan_lut(input logic [StepWidth-1:0] i);
    logic signed [33:0] r;
    r = '0;
    case (i)
      4'd0:  r = 34'sh020000000;
      4'd1:  r = 34'sh012E4051E;
      4'd2:  r = 34'sh009FB385B;
      4'd3:  r = 34'sh0051111D4;
      4'd4:  r = 34'sh0028B0D43;
      4'd5:  r = 34'sh00145D7E1;
      4'd6:  r = 34'sh000A2F61E;
      4'd7:  r = 34'sh000517C55;
      4'd8:  r = 34'sh00028BE53;
      4'd9:  r = 34'sh000145F2F;
      4'd10: r = 34'sh0000A2F98;
      4'd11: r = 34'sh0000517CC;
      4'd12: r = 34'sh000028BE6;
      4'd13: r = 34'sh0000145F3;
      4'd14: r = 34'sh00000A2FA;
      4'd15: r = 34'sh00000517D;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/wdba_if.sv -----
// ----------------------------------------------------------------------------
// wdba_if
// Valid/ready channels: input items, results and the configuration write.
// ----------------------------------------------------------------------------
interface wdba_in_if;
  logic                valid;
  logic                ready;
  logic                func;
  logic signed [23:0]  pos_x;
  logic signed [23:0]  pos_y;
  logic signed [23:0]  pos_z;
  logic signed [15:0]  weight_re;
  logic signed [15:0]  weight_im;
  logic [31:0]         sample_a;
  logic [31:0]         sample_b;
  logic [31:0]         sample_c;
  logic [31:0]         sample_d;
  logic                last;
  modport source (output valid, func, pos_x, pos_y, pos_z, weight_re, weight_im,
                  sample_a, sample_b, sample_c, sample_d, last, input ready);
  modport sink   (input valid, func, pos_x, pos_y, pos_z, weight_re, weight_im,
                  sample_a, sample_b, sample_c, sample_d, last, output ready);
endinterface

interface wdba_out_if;
  logic                valid;
  logic                ready;
  logic signed [47:0]  out_a_re;
  logic signed [47:0]  out_a_im;
  logic signed [47:0]  out_b_re;
  logic signed [47:0]  out_b_im;
  logic signed [47:0]  out_c_re;
  logic signed [47:0]  out_c_im;
  logic signed [47:0]  out_d_re;
  logic signed [47:0]  out_d_im;
  modport source (output valid, out_a_re, out_a_im, out_b_re, out_b_im, out_c_re,
                  out_c_im, out_d_re, out_d_im, input ready);
  modport sink   (input valid, out_a_re, out_a_im, out_b_re, out_b_im, out_c_re,
                  out_c_im, out_d_re, out_d_im, output ready);
endinterface

interface wdba_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] wavenumber;
  modport source (output valid, wavenumber, input ready);
  modport sink   (input valid, wavenumber, output ready);
endinterface

// ----- design/wdba_ctrl.sv -----
// ----------------------------------------------------------------------------
// wdba_ctrl
// Sequencer: datapath direction steps, or phase, cordic, weight, accumulate.
// ----------------------------------------------------------------------------
module wdba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  wdba_pkg::stat_t stat_i,
  output wdba_pkg::cmd_t  cmd_o
);
  import wdba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIR, S_PHASE, S_CORDIC, S_WEIGHT, S_MAC, S_OUT
  } state_e;

  state_e               state_q;
  logic [StepWidth-1:0] cnt_q;
  logic                 out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.sel = cnt_q[SelWidth-1:0];
    cmd_o.load_item = in_valid_i && in_ready_o;
    unique case (state_q)
      S_DIR:    cmd_o.dir_step    = 1'b1;
      S_PHASE: begin
        cmd_o.phase_step = 1'b1;
        cmd_o.cordic_init = (cnt_q[SelWidth-1:0] == 2'd2);
      end
      S_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
      end
      S_WEIGHT: begin
        // round the cordic outputs, then imaginary and real weighted parts
        cmd_o.cordic_done = (cnt_q[SelWidth-1:0] == 2'd0);
        cmd_o.weight_step = (cnt_q[SelWidth-1:0] != 2'd0);
      end
      S_MAC:    cmd_o.mac_step    = 1'b1;
      default: ;
    endcase
    if (state_q == S_DIR && cnt_q[SelWidth-1:0] == 2'd0) cmd_o.start_point = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i && in_ready_o) state_q <= S_DIR;
        end
        S_DIR: begin
          // three direction products on a start, otherwise go to the dot product
          if (!stat_i.is_accum) begin
            if (cnt_q[SelWidth-1:0] == 2'd2) begin
              cnt_q   <= '0;
              state_q <= S_OUT;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end else begin
            state_q <= S_PHASE;
          end
        end
        S_PHASE: begin
          if (cnt_q[SelWidth-1:0] == 2'd2) begin
            cnt_q   <= '0;
            state_q <= S_CORDIC;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_CORDIC: begin
          if (cnt_q == StepWidth'(CordicSteps - 1)) begin
            cnt_q   <= '0;
            state_q <= S_WEIGHT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_WEIGHT: begin
          if (cnt_q[SelWidth-1:0] == 2'd2) begin
            cnt_q   <= '0;
            state_q <= S_MAC;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_MAC: begin
          if (cnt_q[SelWidth-1:0] == 2'd3) begin
            cnt_q   <= '0;
            state_q <= S_OUT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_OUT: begin
          if (stat_i.is_last) out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/wdba_dp.sv -----
// ----------------------------------------------------------------------------
// wdba_dp
// Datapath: direction scaling, phase dot product, cordic, weighting, accumulators.
// ----------------------------------------------------------------------------
module wdba_dp #(
  parameter int unsigned AccWidth  = wdba_pkg::AccWidthDef,
  parameter int unsigned PhaseBits = wdba_pkg::PhaseBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wdba_pkg::cmd_t         cmd_i,
  output wdba_pkg::stat_t        stat_o,
  input  logic [31:0]            wavenumber_i,
  input  logic                   func_i,
  input  logic signed [23:0]     pos_x_i,
  input  logic signed [23:0]     pos_y_i,
  input  logic signed [23:0]     pos_z_i,
  input  logic signed [15:0]     weight_re_i,
  input  logic signed [15:0]     weight_im_i,
  input  logic [31:0]            sample_a_i,
  input  logic [31:0]            sample_b_i,
  input  logic [31:0]            sample_c_i,
  input  logic [31:0]            sample_d_i,
  input  logic                   last_i,
  output logic [8*wdba_pkg::OutWidth-1:0] acc_o
);
  import wdba_pkg::*;

  localparam int unsigned ProdW = DirWidth + PosWidth;

  // captured item
  logic                     func_q, last_q;
  logic signed [23:0]       pos_q [3];
  logic signed [15:0]       wre_q, wim_q;
  logic [31:0]              smp_q [NumSamples];

  logic signed [DirWidth-1:0] dir_q [3];
  logic [63:0]              sum_q;
  logic signed [AccWidth-1:0] acc_q [8];

  logic signed [33:0]       cx_q, cy_q, cz_q;
  logic                     neg_q;
  logic [StepWidth-1:0]     step_q;
  logic signed [16:0]       cos_q, sin_q;
  logic signed [33:0]       wpr_q [2];
  logic signed [17:0]       wr_q, wi_q;

  assign stat_o.is_accum = func_q;
  assign stat_o.is_last  = last_q;

  // one multiplier per cycle through the selected axis
  logic signed [23:0]       pos_sel;
  logic signed [DirWidth-1:0] dir_sel;
  logic signed [ProdW-1:0]  dot_prod;
  logic signed [16:0]       dcos;
  logic signed [DirWidth-1:0] dir_prod;
  always_comb begin
    pos_sel  = pos_q[cmd_i.sel];
    dir_sel  = dir_q[cmd_i.sel];
    dot_prod = dir_sel * pos_sel;
    dcos     = {pos_sel[15], pos_sel[15:0]};
    dir_prod = DirWidth'(dcos * $signed({1'b0, wavenumber_i}));
  end

  // phase to quadrant-folded angle
  logic [63:0]        sum_n;
  logic [PhaseBits-1:0] phase;
  logic signed [33:0] ang, ang_f;
  logic               fold;
  always_comb begin
    sum_n = sum_q + 64'(dot_prod);
    phase = sum_n[46 -: PhaseBits];
    ang   = 34'(signed'({phase, {(32-PhaseBits){1'b0}}}));
    fold  = 1'b0;
    ang_f = ang;
    if (ang > 34'sh040000000) begin
      ang_f = ang - 34'sh080000000;
      fold  = 1'b1;
    end else if (ang < -34'sh040000000) begin
      ang_f = ang + 34'sh080000000;
      fold  = 1'b1;
    end
  end

  // rounding of the cordic outputs
  logic signed [33:0] xf, yf;
  logic signed [18:0] xr, yr;
  always_comb begin
    xf = neg_q ? -cx_q : cx_q;
    yf = neg_q ? -cy_q : cy_q;
    xr = 19'((xf + 34'sd16384) >>> 15);
    yr = 19'((yf + 34'sd16384) >>> 15);
  end

  function automatic logic signed [16:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767)       return 17'sd32767;
    else if (v < -19'sd32768) return -17'sd32768;
    else                      return 17'(v);
  endfunction

  function automatic logic signed [33:0] weight_mul(input logic signed [15:0] a,
                                                    input logic signed [16:0] b);
    return 34'(a * b);
  endfunction

  // weighting: two products a cycle, imaginary then real
  logic signed [33:0] wp0, wp1;
  always_comb begin
    wp0 = 34'(weight_mul(wre_q, cmd_i.sel[0] ? sin_q : cos_q));
    wp1 = 34'(weight_mul(wim_q, cmd_i.sel[0] ? cos_q : sin_q));
  end

  function automatic logic signed [AccWidth-1:0] sat_add(
      input logic signed [AccWidth-1:0] a, input logic signed [35:0] t);
    logic signed [AccWidth+36:0] s;
    logic signed [AccWidth+36:0] mx, mn;
    s  = (AccWidth+37)'(a) + (AccWidth+37)'(t);
    mx = (AccWidth+37)'({1'b0, {(AccWidth-1){1'b1}}});
    mn = -mx - 1;
    if (s > mx)      return {1'b0, {(AccWidth-1){1'b1}}};
    else if (s < mn) return {1'b1, {(AccWidth-1){1'b0}}};
    else             return AccWidth'(s);
  endfunction

  // one sample a cycle, four narrow products
  logic [31:0]        smp;
  logic signed [15:0] sre, sim;
  logic signed [35:0] t_re, t_im;
  logic signed [AccWidth-1:0] acc_re, acc_im, nre, nim;
  always_comb begin
    smp   = smp_q[cmd_i.sel];
    sre   = smp[31:16];
    sim   = smp[15:0];
    t_re  = 36'(sre * wr_q) - 36'(sim * wi_q);
    t_im  = 36'(sim * wr_q) + 36'(sre * wi_q);
    acc_re = acc_q[{cmd_i.sel, 1'b0}];
    acc_im = acc_q[{cmd_i.sel, 1'b1}];
    nre   = sat_add(acc_re, t_re);
    nim   = sat_add(acc_im, t_im);
  end

  logic signed [33:0] sx, sy;
  always_comb begin
    sx = cx_q >>> step_q;
    sy = cy_q >>> step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q <= 1'b0;
      last_q <= 1'b0;
      for (int i = 0; i < 3; i++) dir_q[i] <= '0;
      for (int i = 0; i < 8; i++) acc_q[i] <= '0;
    end else begin
      if (cmd_i.load_item) begin
        func_q <= func_i;
        last_q <= last_i;
      end
      if (cmd_i.dir_step && !func_q) dir_q[cmd_i.sel] <= dir_prod;
      if (cmd_i.start_point && !func_q) begin
        for (int i = 0; i < 8; i++) acc_q[i] <= '0;
      end
      if (cmd_i.mac_step) begin
        acc_q[{cmd_i.sel, 1'b0}] <= nre;
        acc_q[{cmd_i.sel, 1'b1}] <= nim;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      wre_q    <= weight_re_i;
      wim_q    <= weight_im_i;
      smp_q[0] <= sample_a_i;
      smp_q[1] <= sample_b_i;
      smp_q[2] <= sample_c_i;
      smp_q[3] <= sample_d_i;
      sum_q    <= '0;
    end
    if (cmd_i.phase_step) sum_q <= sum_n;
    if (cmd_i.cordic_init) begin
      cz_q   <= ang_f;
      neg_q  <= fold;
      cx_q   <= 34'(CordicGain);
      cy_q   <= '0;
      step_q <= '0;
    end
    if (cmd_i.cordic_step) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - sy;
        cy_q <= cy_q + sx;
        cz_q <= cz_q - atan_lut(step_q);
      end else begin
        cx_q <= cx_q + sy;
        cy_q <= cy_q - sx;
        cz_q <= cz_q + atan_lut(step_q);
      end
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.cordic_done) begin
      cos_q <= sat16(xr);
      sin_q <= sat16(yr);
    end
    if (cmd_i.weight_step) begin
      wpr_q[0] <= wp0;
      wpr_q[1] <= wp1;
    end
  end

  // rounded weighted phasor, formed over the two weight steps
  logic signed [33:0] wr_full, wi_full;
  always_comb begin
    wr_full = wpr_q[0];
    wi_full = wpr_q[1];
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.weight_step) begin
      if (cmd_i.sel[0]) wi_q <= 18'((wp0 + wp1 + 34'sd16384) >>> 15);
      else              wr_q <= 18'((wp0 - wp1 + 34'sd16384) >>> 15);
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_out
    assign acc_o[g*OutWidth +: OutWidth] = OutWidth'(acc_q[g]);
  end

  logic unused;
  assign unused = ^{wr_full, wi_full};

endmodule

// ----- design/weighted_dft_beamform_accumulator.sv -----
// ----------------------------------------------------------------------------
// weighted_dft_beamform_accumulator
// Weighted direct Fourier beamformer with four complex sample accumulators.
// ----------------------------------------------------------------------------
// Use: write the wavenumber on cfg while idle. Send a start item (func 0) with
// the direction cosines, then one accumulate item (func 1) per element; set
// last on the final item of a point to get the eight sums on the out channel.
// Sequence: an accumulate item runs through item decode, the three-step phase
// dot product, the 16 cordic iterations, which dominate, the cordic rounding,
// the imaginary and real weights and the four sample accumulations, then the
// result check and the return to idle; a start item runs the three direction
// products instead. No new item is taken before the return to idle.
// A result sits in the output register until taken; the next item is not
// accepted while it waits. Reset clears the wavenumber, the scaled direction
// and the accumulators.
// ----------------------------------------------------------------------------
module weighted_dft_beamform_accumulator #(
  parameter int unsigned AccWidth  = wdba_pkg::AccWidthDef,
  parameter int unsigned PhaseBits = wdba_pkg::PhaseBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  wdba_cfg_if.sink   cfg,
  wdba_in_if.sink    in_ch,
  wdba_out_if.source out_ch
);
  import wdba_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [31:0] wavenumber_q;
  logic [8*OutWidth-1:0] acc;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wavenumber_q <= '0;
    else if (cfg.valid) wavenumber_q <= cfg.wavenumber;
  end

  wdba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid), .in_ready_o (in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .stat_i(stat), .cmd_o(cmd)
  );

  wdba_dp #(.AccWidth(AccWidth), .PhaseBits(PhaseBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .wavenumber_i(wavenumber_q),
    .func_i(in_ch.func), .pos_x_i(in_ch.pos_x), .pos_y_i(in_ch.pos_y),
    .pos_z_i(in_ch.pos_z), .weight_re_i(in_ch.weight_re),
    .weight_im_i(in_ch.weight_im), .sample_a_i(in_ch.sample_a),
    .sample_b_i(in_ch.sample_b), .sample_c_i(in_ch.sample_c),
    .sample_d_i(in_ch.sample_d), .last_i(in_ch.last), .acc_o(acc)
  );

  assign out_ch.out_a_re = acc[0*OutWidth +: OutWidth];
  assign out_ch.out_a_im = acc[1*OutWidth +: OutWidth];
  assign out_ch.out_b_re = acc[2*OutWidth +: OutWidth];
  assign out_ch.out_b_im = acc[3*OutWidth +: OutWidth];
  assign out_ch.out_c_re = acc[4*OutWidth +: OutWidth];
  assign out_ch.out_c_im = acc[5*OutWidth +: OutWidth];
  assign out_ch.out_d_re = acc[6*OutWidth +: OutWidth];
  assign out_ch.out_d_im = acc[7*OutWidth +: OutWidth];

  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> !in_ch.ready) else $error("input taken with result pending");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.out_a_re))
    else $error("result changed while stalled");
  a_no_mac_on_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mac_step |-> !in_ch.ready) else $error("accumulate while idle");

endmodule
